### hdl/cbm_pkg.sv
package cbm_pkg;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	localparam int AddrW   = 16;
	localparam int DataW   = 8;
	localparam int PhysW   = 21;
	localparam int TargetW = 3;
	localparam int MapperW = 2;

	// Mapper types as written to the configuration register.
	localparam logic [MapperW-1:0] MAPPER_NONE = 2'd0;
	localparam logic [MapperW-1:0] MAPPER_MBC1 = 2'd1;
	localparam logic [MapperW-1:0] MAPPER_MBC2 = 2'd2;

	// Result target codes.
	localparam logic [TargetW-1:0] TGT_PASS     = 3'd0;
	localparam logic [TargetW-1:0] TGT_ROM      = 3'd1;
	localparam logic [TargetW-1:0] TGT_RAM      = 3'd2;
	localparam logic [TargetW-1:0] TGT_CTRL     = 3'd3;
	localparam logic [TargetW-1:0] TGT_RAM_DROP = 3'd4;

	// Access kinds as sorted by the front end.
	typedef enum logic [2:0] {
		KIND_PASS,
		KIND_ROM_RD,
		KIND_RAM_RD,
		KIND_CTRL_WR,
		KIND_RAM_WR
	} cbm_kind_t;

	typedef struct packed {
		cbm_kind_t          kind;
		logic [AddrW-1:0]   addr;
		logic [DataW-1:0]   data;
	} cbm_item_t;

	typedef struct packed {
		logic      valid;
		cbm_item_t item;
	} cbm_qhead_t;

endpackage

### hdl/cbm_front.sv
module cbm_front (
	input  logic                  push,
	input  logic                  op,
	input  logic [15:0]           bus_address,
	input  logic [7:0]            write_data,
	input  logic                  q_full,
	output logic                  full,
	output logic                  q_wr,
	output cbm_pkg::cbm_item_t    q_item
);
	import cbm_pkg::*;

	cbm_kind_t kind;

	always_comb begin
		if (op) begin
			if (bus_address[15:14] == 2'b01) begin
				kind = KIND_ROM_RD;
			end else if (bus_address[15:13] == 3'b101) begin
				kind = KIND_RAM_RD;
			end else begin
				kind = KIND_PASS;
			end
		end else begin
			if (!bus_address[15]) begin
				kind = KIND_CTRL_WR;
			end else if (bus_address[15:13] == 3'b101) begin
				kind = KIND_RAM_WR;
			end else begin
				kind = KIND_PASS;
			end
		end
	end

	assign full        = q_full;
	assign q_wr        = push && !q_full;
	assign q_item.kind = kind;
	assign q_item.addr = bus_address;
	assign q_item.data = write_data;

endmodule

### hdl/cbm_queue.sv
module cbm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  cbm_pkg::cbm_item_t    wr_item,
	input  logic                  rd,
	output logic                  full,
	output cbm_pkg::cbm_qhead_t   head
);
	import cbm_pkg::*;

	cbm_item_t               mem_q [QueueDepth];
	logic [QueuePtrW-1:0]    wr_ptr_q;
	logic [QueuePtrW-1:0]    rd_ptr_q;
	logic [QueueCntW-1:0]    count_q;
	logic                    do_rd;

	assign full       = (count_q == QueueCntW'(QueueDepth));
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_rd      = rd && head.valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/cbm_back.sv
module cbm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [1:0]            cfg_data,
	input  cbm_pkg::cbm_qhead_t   head,
	output logic                  head_rd,
	input  logic                  pop,
	output logic                  empty,
	output logic [2:0]            target,
	output logic [20:0]           physical_address,
	output logic                  ram_enabled
);
	import cbm_pkg::*;

	typedef struct packed {
		logic [TargetW-1:0] target;
		logic [PhysW-1:0]   phys;
		logic               ram_en;
	} cbm_result_t;

	logic [MapperW-1:0] mapper_q;
	logic               ram_en_q;
	logic [6:0]         rom_bank_q;
	logic [1:0]         ram_bank_q;
	logic               rom_mode_q;

	logic               ram_en_d;
	logic [6:0]         rom_bank_d;
	logic [1:0]         ram_bank_d;
	logic               rom_mode_d;

	logic               mbc1;
	logic               mbc2;
	cbm_item_t          it;
	cbm_result_t        res;

	// Two-entry result buffer so the back end keeps draining while a result waits.
	cbm_result_t        obuf_q [2];
	logic               owr_ptr_q;
	logic               ord_ptr_q;
	logic [1:0]         ocnt_q;
	logic               do_pop;
	logic               do_proc;

	function automatic logic [6:0] bank_nz(input logic [6:0] b);
		return (b == 7'd0) ? 7'd1 : b;
	endfunction

	assign mbc1 = (mapper_q == MAPPER_MBC1);
	assign mbc2 = (mapper_q == MAPPER_MBC2);
	assign it   = head.item;

	assign empty   = (ocnt_q == 2'd0);
	assign do_pop  = pop && !empty;
	assign head_rd = (ocnt_q != 2'd2) || do_pop;
	assign do_proc = head_rd && head.valid;

	// Register update for control writes; all other kinds leave state alone.
	always_comb begin
		ram_en_d   = ram_en_q;
		rom_bank_d = rom_bank_q;
		ram_bank_d = ram_bank_q;
		rom_mode_d = rom_mode_q;
		if (it.kind == KIND_CTRL_WR) begin
			case (it.addr[14:13])
				2'd0: begin
					if ((mbc1 || (mbc2 && !it.addr[8]))) begin
						if (it.data[3:0] == 4'hA) begin
							ram_en_d = 1'b1;
						end else if (it.data[3:0] == 4'h0) begin
							ram_en_d = 1'b0;
						end
					end
				end
				2'd1: begin
					if (mbc2) begin
						rom_bank_d = bank_nz({3'b000, it.data[3:0]});
					end else if (mbc1) begin
						rom_bank_d = bank_nz({rom_bank_q[6:5], it.data[4:0]});
					end
				end
				2'd2: begin
					if (mbc1) begin
						if (rom_mode_q) begin
							rom_bank_d = bank_nz({it.data[1:0], rom_bank_q[4:0]});
						end else begin
							ram_bank_d = it.data[1:0];
						end
					end
				end
				default: begin
					if (mbc1) begin
						rom_mode_d = !it.data[0];
						if (!it.data[0]) begin
							ram_bank_d = 2'd0;
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		res.ram_en = ram_en_d;
		case (it.kind)
			KIND_ROM_RD: begin
				res.target = TGT_ROM;
				res.phys   = {rom_bank_q, it.addr[13:0]};
			end
			KIND_RAM_RD: begin
				res.target = TGT_RAM;
				res.phys   = PhysW'({ram_bank_q, it.addr[12:0]});
			end
			KIND_CTRL_WR: begin
				res.target = TGT_CTRL;
				res.phys   = '0;
			end
			KIND_RAM_WR: begin
				if (ram_en_q) begin
					res.target = TGT_RAM;
					res.phys   = PhysW'({ram_bank_q, it.addr[12:0]});
				end else begin
					res.target = TGT_RAM_DROP;
					res.phys   = '0;
				end
			end
			default: begin
				res.target = TGT_PASS;
				res.phys   = PhysW'(it.addr);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_proc) begin
			obuf_q[owr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_q   <= MAPPER_NONE;
			ram_en_q   <= 1'b0;
			rom_bank_q <= 7'd1;
			ram_bank_q <= 2'd0;
			rom_mode_q <= 1'b1;
			owr_ptr_q  <= 1'b0;
			ord_ptr_q  <= 1'b0;
			ocnt_q     <= 2'd0;
		end else begin
			if (cfg_wr) begin
				mapper_q <= cfg_data;
			end
			if (do_proc) begin
				ram_en_q   <= ram_en_d;
				rom_bank_q <= rom_bank_d;
				ram_bank_q <= ram_bank_d;
				rom_mode_q <= rom_mode_d;
				owr_ptr_q  <= !owr_ptr_q;
			end
			if (do_pop) begin
				ord_ptr_q <= !ord_ptr_q;
			end
			if (do_proc && !do_pop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (do_pop && !do_proc) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	assign target           = obuf_q[ord_ptr_q].target;
	assign physical_address = obuf_q[ord_ptr_q].phys;
	assign ram_enabled      = obuf_q[ord_ptr_q].ram_en;

endmodule

### hdl/cartridge_bank_mapper.sv
// Bank mapper for MBC1 and MBC2 cartridges. Every bus access pushed in gives
// exactly one result, in order: the target class, the physical cartridge
// address and the RAM enable flag as it stands after the access. The block
// takes one access per clock cycle while full is low; an accepted access is
// registered in the queue and then in the result buffer before it can be
// popped. The rate is set by the back end, which decodes the queue head and
// updates the bank registers as it stores its result. A four-entry queue sits
// between the classifying front end and the back end, and a two-entry result
// buffer feeds the output side, so either side may stall without losing a
// cycle on the other. The mapper type is written through the cfg port, which
// is always ready; write it only while no accesses are in flight.
module cartridge_bank_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  target,
	output logic [20:0] physical_address,
	output logic        ram_enabled
);
	import cbm_pkg::*;

	logic       q_full;
	logic       q_wr;
	cbm_item_t  q_item;
	cbm_qhead_t q_head;
	logic       q_rd;

	assign cfg_ready = 1'b1;

	cbm_front u_front (
		.push        (push),
		.op          (op),
		.bus_address (bus_address),
		.write_data  (write_data),
		.q_full      (q_full),
		.full        (full),
		.q_wr        (q_wr),
		.q_item      (q_item)
	);

	cbm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (q_item),
		.rd      (q_rd),
		.full    (q_full),
		.head    (q_head)
	);

	cbm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr           (cfg_valid && cfg_ready),
		.cfg_data         (cfg_data),
		.head             (q_head),
		.head_rd          (q_rd),
		.pop              (pop),
		.empty            (empty),
		.target           (target),
		.physical_address (physical_address),
		.ram_enabled      (ram_enabled)
	);

endmodule
